// ===== rtl/scop_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sphere versus capsule overlap unit.
// No dependencies; every other file takes its names from here by scope.
package scop_pkg;

  localparam int RADIUS_BITS = 15;
  localparam int RSUM_BITS   = RADIUS_BITS + 1;
  localparam int R2_BITS     = 2 * RSUM_BITS;

  typedef enum logic [1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_BOTTOM   = 2'd1,
    REGION_TOP      = 2'd2
  } region_t;

endpackage

// ===== rtl/scop_front.sv =====
`timescale 1ns / 1ps
// Front half of the overlap pipeline: segment vectors, raw products and dot/cross sums.
// Three register stages; depends on scop_pkg for the radius widths.
module scop_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         sphere_x,
  input  logic signed [COORD_BITS-1:0]         sphere_y,
  input  logic signed [COORD_BITS-1:0]         sphere_z,
  input  logic        [scop_pkg::RADIUS_BITS-1:0] sphere_radius,
  input  logic signed [COORD_BITS-1:0]         top_x,
  input  logic signed [COORD_BITS-1:0]         top_y,
  input  logic signed [COORD_BITS-1:0]         top_z,
  input  logic signed [COORD_BITS-1:0]         bottom_x,
  input  logic signed [COORD_BITS-1:0]         bottom_y,
  input  logic signed [COORD_BITS-1:0]         bottom_z,
  input  logic        [scop_pkg::RADIUS_BITS-1:0] capsule_radius,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [2*COORD_BITS+2:0]       t,
  output logic        [2*COORD_BITS+1:0]       len2,
  output logic        [2*COORD_BITS+1:0]       dist_top,
  output logic        [2*COORD_BITS+1:0]       dist_bot,
  output logic signed [2*COORD_BITS+2:0]       cross0,
  output logic signed [2*COORD_BITS+2:0]       cross1,
  output logic signed [2*COORD_BITS+2:0]       cross2,
  output logic        [scop_pkg::R2_BITS-1:0]  r2
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int TW = 2 * COORD_BITS + 3;
  localparam int LW = 2 * COORD_BITS + 2;
  localparam int CW = 2 * COORD_BITS + 3;
  localparam int SW = scop_pkg::RSUM_BITS;
  localparam int QW = scop_pkg::R2_BITS;

  logic signed [COORD_BITS-1:0] s_in [3];
  logic signed [COORD_BITS-1:0] t_in [3];
  logic signed [COORD_BITS-1:0] b_in [3];

  logic signed [DW-1:0] d_nxt [3];
  logic signed [DW-1:0] v_nxt [3];
  logic signed [DW-1:0] w_nxt [3];
  logic        [SW-1:0] rsum_nxt;
  logic signed [DW-1:0] d_r [3];
  logic signed [DW-1:0] v_r [3];
  logic signed [DW-1:0] w_r [3];
  logic        [SW-1:0] rsum_r;

  logic signed [PW-1:0] tp_nxt [3];
  logic signed [PW-1:0] lp_nxt [3];
  logic signed [PW-1:0] vp_nxt [3];
  logic signed [PW-1:0] wp_nxt [3];
  logic signed [PW-1:0] xa_nxt [3];
  logic signed [PW-1:0] xb_nxt [3];
  logic        [QW-1:0] r2a_nxt;
  logic signed [PW-1:0] tp_r [3];
  logic signed [PW-1:0] lp_r [3];
  logic signed [PW-1:0] vp_r [3];
  logic signed [PW-1:0] wp_r [3];
  logic signed [PW-1:0] xa_r [3];
  logic signed [PW-1:0] xb_r [3];
  logic        [QW-1:0] r2a_r;

  logic signed [TW-1:0] t_nxt;
  logic        [LW-1:0] len2_nxt;
  logic        [LW-1:0] dtop_nxt;
  logic        [LW-1:0] dbot_nxt;
  logic signed [CW-1:0] cross_nxt [3];
  logic signed [TW-1:0] t_r;
  logic        [LW-1:0] len2_r;
  logic        [LW-1:0] dtop_r;
  logic        [LW-1:0] dbot_r;
  logic signed [CW-1:0] cross_r [3];
  logic        [QW-1:0] r2b_r;

  logic vld1_r, vld2_r, vld3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !vld3_r || out_ready;
  assign rdy2     = !vld2_r || rdy3;
  assign rdy1     = !vld1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s_in[0] = sphere_x;
    s_in[1] = sphere_y;
    s_in[2] = sphere_z;
    t_in[0] = top_x;
    t_in[1] = top_y;
    t_in[2] = top_z;
    b_in[0] = bottom_x;
    b_in[1] = bottom_y;
    b_in[2] = bottom_z;
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = DW'(b_in[i]) - DW'(t_in[i]);
      v_nxt[i] = DW'(s_in[i]) - DW'(t_in[i]);
      w_nxt[i] = DW'(s_in[i]) - DW'(b_in[i]);
    end
    rsum_nxt = SW'(sphere_radius) + SW'(capsule_radius);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tp_nxt[i] = PW'(d_r[i]) * PW'(v_r[i]);
      lp_nxt[i] = PW'(d_r[i]) * PW'(d_r[i]);
      vp_nxt[i] = PW'(v_r[i]) * PW'(v_r[i]);
      wp_nxt[i] = PW'(w_r[i]) * PW'(w_r[i]);
    end
    xa_nxt[0] = PW'(v_r[1]) * PW'(d_r[2]);
    xb_nxt[0] = PW'(v_r[2]) * PW'(d_r[1]);
    xa_nxt[1] = PW'(v_r[2]) * PW'(d_r[0]);
    xb_nxt[1] = PW'(v_r[0]) * PW'(d_r[2]);
    xa_nxt[2] = PW'(v_r[0]) * PW'(d_r[1]);
    xb_nxt[2] = PW'(v_r[1]) * PW'(d_r[0]);
    r2a_nxt   = QW'(rsum_r) * QW'(rsum_r);
  end

  always_comb begin
    t_nxt    = TW'(tp_r[0]) + TW'(tp_r[1]) + TW'(tp_r[2]);
    len2_nxt = LW'(lp_r[0]) + LW'(lp_r[1]) + LW'(lp_r[2]);
    dtop_nxt = LW'(vp_r[0]) + LW'(vp_r[1]) + LW'(vp_r[2]);
    dbot_nxt = LW'(wp_r[0]) + LW'(wp_r[1]) + LW'(wp_r[2]);
    for (int i = 0; i < 3; i++) begin
      cross_nxt[i] = CW'(xa_r[i]) - CW'(xb_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r <= in_valid;
      if (rdy2) vld2_r <= vld1_r;
      if (rdy3) vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= d_nxt[i];
        v_r[i] <= v_nxt[i];
        w_r[i] <= w_nxt[i];
      end
      rsum_r <= rsum_nxt;
    end
    if (rdy2) begin
      for (int i = 0; i < 3; i++) begin
        tp_r[i] <= tp_nxt[i];
        lp_r[i] <= lp_nxt[i];
        vp_r[i] <= vp_nxt[i];
        wp_r[i] <= wp_nxt[i];
        xa_r[i] <= xa_nxt[i];
        xb_r[i] <= xb_nxt[i];
      end
      r2a_r <= r2a_nxt;
    end
    if (rdy3) begin
      t_r    <= t_nxt;
      len2_r <= len2_nxt;
      dtop_r <= dtop_nxt;
      dbot_r <= dbot_nxt;
      for (int i = 0; i < 3; i++) begin
        cross_r[i] <= cross_nxt[i];
      end
      r2b_r <= r2a_r;
    end
  end

  assign out_valid = vld3_r;
  assign t         = t_r;
  assign len2      = len2_r;
  assign dist_top  = dtop_r;
  assign dist_bot  = dbot_r;
  assign cross0    = cross_r[0];
  assign cross1    = cross_r[1];
  assign cross2    = cross_r[2];
  assign r2        = r2b_r;

endmodule

// ===== rtl/scop_back.sv =====
`timescale 1ns / 1ps
// Back half of the overlap pipeline: region choice, split squaring and the final compare.
// Three register stages, the last one being the output register; depends on scop_pkg.
module scop_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [2*COORD_BITS+2:0]      t,
  input  logic        [2*COORD_BITS+1:0]      len2,
  input  logic        [2*COORD_BITS+1:0]      dist_top,
  input  logic        [2*COORD_BITS+1:0]      dist_bot,
  input  logic signed [2*COORD_BITS+2:0]      cross0,
  input  logic signed [2*COORD_BITS+2:0]      cross1,
  input  logic signed [2*COORD_BITS+2:0]      cross2,
  input  logic        [scop_pkg::R2_BITS-1:0] r2,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic        [1:0]                   region
);

  localparam int TW   = 2 * COORD_BITS + 3;
  localparam int LW   = 2 * COORD_BITS + 2;
  localparam int CW   = 2 * COORD_BITS + 3;
  localparam int K    = COORD_BITS + 1;
  localparam int CHW  = CW - K;
  localparam int HPW  = 2 * CHW;
  localparam int LLW  = 2 * K;
  localparam int SQW  = 4 * COORD_BITS + 6;
  localparam int SQU  = 4 * COORD_BITS + 2;
  localparam int XW   = 4 * COORD_BITS + 4;
  localparam int QW   = scop_pkg::R2_BITS;
  localparam int LL   = COORD_BITS + 1;
  localparam int LH   = LW - LL;
  localparam int RLW  = QW + LL;
  localparam int RHW  = QW + LH;
  localparam int LIMW = QW + LW;
  localparam int FW   = (XW > LIMW) ? XW : LIMW;
  localparam int DCW  = (LW > QW) ? LW : QW;

  logic signed [CW-1:0] cr [3];

  scop_pkg::region_t    region4_nxt;
  logic                 htop4_nxt;
  logic                 hbot4_nxt;
  logic signed [HPW-1:0] hh_nxt [3];
  logic signed [HPW-1:0] hl_nxt [3];
  logic        [LLW-1:0] ll_nxt [3];
  logic        [RLW-1:0] rl_nxt;
  logic        [RHW-1:0] rh_nxt;

  scop_pkg::region_t    region4_r;
  logic                 htop4_r;
  logic                 hbot4_r;
  logic signed [HPW-1:0] hh_r [3];
  logic signed [HPW-1:0] hl_r [3];
  logic        [LLW-1:0] ll_r [3];
  logic        [RLW-1:0] rl_r;
  logic        [RHW-1:0] rh_r;

  logic signed [SQW-1:0] acc [3];
  logic        [SQU-1:0] sq_nxt [3];
  logic        [LIMW-1:0] lim_nxt;
  logic        [SQU-1:0] sq_r [3];
  logic        [LIMW-1:0] lim_r;
  scop_pkg::region_t    region5_r;
  logic                 htop5_r;
  logic                 hbot5_r;

  logic        [XW-1:0] xsum;
  logic                 hit_nxt;
  logic                 hit_r;
  scop_pkg::region_t    region6_r;

  logic vld4_r, vld5_r, vld6_r;
  logic rdy4, rdy5, rdy6;

  assign rdy6     = !vld6_r || out_ready;
  assign rdy5     = !vld5_r || rdy6;
  assign rdy4     = !vld4_r || rdy5;
  assign in_ready = rdy4;

  assign cr[0] = cross0;
  assign cr[1] = cross1;
  assign cr[2] = cross2;

  always_comb begin
    if (len2 == '0 || t <= 0) begin
      region4_nxt = scop_pkg::REGION_TOP;
    end else if (t > $signed(TW'(len2))) begin
      region4_nxt = scop_pkg::REGION_BOTTOM;
    end else begin
      region4_nxt = scop_pkg::REGION_INTERIOR;
    end
    htop4_nxt = DCW'(dist_top) < DCW'(r2);
    hbot4_nxt = DCW'(dist_bot) < DCW'(r2);
    for (int i = 0; i < 3; i++) begin
      hh_nxt[i] = HPW'($signed(cr[i][CW-1:K])) * HPW'($signed(cr[i][CW-1:K]));
      hl_nxt[i] = HPW'($signed(cr[i][CW-1:K])) * HPW'($signed({1'b0, cr[i][K-1:0]}));
      ll_nxt[i] = LLW'(cr[i][K-1:0]) * LLW'(cr[i][K-1:0]);
    end
    rl_nxt = RLW'(r2) * RLW'(len2[LL-1:0]);
    rh_nxt = RHW'(r2) * RHW'(len2[LW-1:LL]);
  end

  // Square of a cross component rebuilt from its split partial products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (SQW'(hh_r[i]) <<< (2 * K)) + (SQW'(hl_r[i]) <<< (K + 1))
             + SQW'($signed({1'b0, ll_r[i]}));
      sq_nxt[i] = SQU'(acc[i]);
    end
    lim_nxt = (LIMW'(rh_r) << LL) + LIMW'(rl_r);
  end

  always_comb begin
    xsum = XW'(sq_r[0]) + XW'(sq_r[1]) + XW'(sq_r[2]);
    case (region5_r)
      scop_pkg::REGION_INTERIOR: hit_nxt = FW'(xsum) < FW'(lim_r);
      scop_pkg::REGION_BOTTOM:   hit_nxt = hbot5_r;
      default:                   hit_nxt = htop5_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      if (rdy4) vld4_r <= in_valid;
      if (rdy5) vld5_r <= vld4_r;
      if (rdy6) vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      region4_r <= region4_nxt;
      htop4_r   <= htop4_nxt;
      hbot4_r   <= hbot4_nxt;
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= hh_nxt[i];
        hl_r[i] <= hl_nxt[i];
        ll_r[i] <= ll_nxt[i];
      end
      rl_r <= rl_nxt;
      rh_r <= rh_nxt;
    end
    if (rdy5) begin
      region5_r <= region4_r;
      htop5_r   <= htop4_r;
      hbot5_r   <= hbot4_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= sq_nxt[i];
      end
      lim_r <= lim_nxt;
    end
    if (rdy6) begin
      hit_r     <= hit_nxt;
      region6_r <= region5_r;
    end
  end

  assign out_valid = vld6_r;
  assign hit       = hit_r;
  assign region    = region6_r;

endmodule

// ===== rtl/sphere_capsule_overlap_unit.sv =====
`timescale 1ns / 1ps
// Sphere versus capsule overlap test, one query per beat, one result per query.
// Top level; instantiates scop_front and scop_back, widths from scop_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall with the sphere centre and radius and the
//   capsule top point, bottom point and radius, one query per beat.
//   Result channel: out_valid / out_stall with out_hit (strict overlap) and
//   out_region (0 segment interior, 1 bottom end, 2 top end).
//   The datapath is a six stage pipeline; a query moves through the stages in
//   order to the output register, where it can be taken. While out_stall is
//   low, throughput is one query per cycle; each stage has its own valid bit and
//   loads whenever it is empty or the stage after it moves on, so bubbles close
//   up and new queries are taken while a finished result waits to be taken.
//   The widest multipliers are in the squaring stage, where each cross product
//   component is split into two halves.
//   While out_stall is high the result holds; queries keep entering until the
//   pipeline is full, then in_stall rises.
//   Synchronous reset empties every stage; no result is pending after reset.
module sphere_capsule_overlap_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          in_sphere_x,
  input  logic signed [COORD_BITS-1:0]          in_sphere_y,
  input  logic signed [COORD_BITS-1:0]          in_sphere_z,
  input  logic        [scop_pkg::RADIUS_BITS-1:0] in_sphere_radius,
  input  logic signed [COORD_BITS-1:0]          in_top_x,
  input  logic signed [COORD_BITS-1:0]          in_top_y,
  input  logic signed [COORD_BITS-1:0]          in_top_z,
  input  logic signed [COORD_BITS-1:0]          in_bottom_x,
  input  logic signed [COORD_BITS-1:0]          in_bottom_y,
  input  logic signed [COORD_BITS-1:0]          in_bottom_z,
  input  logic        [scop_pkg::RADIUS_BITS-1:0] in_capsule_radius,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_hit,
  output logic        [1:0]                     out_region
);

  logic                          front_ready;
  logic                          mid_valid;
  logic                          mid_ready;
  logic signed [2*COORD_BITS+2:0] mid_t;
  logic        [2*COORD_BITS+1:0] mid_len2;
  logic        [2*COORD_BITS+1:0] mid_dist_top;
  logic        [2*COORD_BITS+1:0] mid_dist_bot;
  logic signed [2*COORD_BITS+2:0] mid_cross0;
  logic signed [2*COORD_BITS+2:0] mid_cross1;
  logic signed [2*COORD_BITS+2:0] mid_cross2;
  logic        [scop_pkg::R2_BITS-1:0] mid_r2;

  assign in_stall = !front_ready;

  scop_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (front_ready),
    .sphere_x      (in_sphere_x),
    .sphere_y      (in_sphere_y),
    .sphere_z      (in_sphere_z),
    .sphere_radius (in_sphere_radius),
    .top_x         (in_top_x),
    .top_y         (in_top_y),
    .top_z         (in_top_z),
    .bottom_x      (in_bottom_x),
    .bottom_y      (in_bottom_y),
    .bottom_z      (in_bottom_z),
    .capsule_radius(in_capsule_radius),
    .out_valid     (mid_valid),
    .out_ready     (mid_ready),
    .t             (mid_t),
    .len2          (mid_len2),
    .dist_top      (mid_dist_top),
    .dist_bot      (mid_dist_bot),
    .cross0        (mid_cross0),
    .cross1        (mid_cross1),
    .cross2        (mid_cross2),
    .r2            (mid_r2)
  );

  scop_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (mid_valid),
    .in_ready (mid_ready),
    .t        (mid_t),
    .len2     (mid_len2),
    .dist_top (mid_dist_top),
    .dist_bot (mid_dist_bot),
    .cross0   (mid_cross0),
    .cross1   (mid_cross1),
    .cross2   (mid_cross2),
    .r2       (mid_r2),
    .out_valid(out_valid),
    .out_ready(!out_stall),
    .hit      (out_hit),
    .region   (out_region)
  );

endmodule

// ===== rtl/scop_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for sphere_capsule_overlap_unit, attached by the bind below.
// Depends on scop_pkg for the radius width only.
module scop_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic signed [COORD_BITS-1:0]          in_sphere_x,
  input logic signed [COORD_BITS-1:0]          in_sphere_y,
  input logic signed [COORD_BITS-1:0]          in_sphere_z,
  input logic        [scop_pkg::RADIUS_BITS-1:0] in_sphere_radius,
  input logic signed [COORD_BITS-1:0]          in_top_x,
  input logic signed [COORD_BITS-1:0]          in_top_y,
  input logic signed [COORD_BITS-1:0]          in_top_z,
  input logic signed [COORD_BITS-1:0]          in_bottom_x,
  input logic signed [COORD_BITS-1:0]          in_bottom_y,
  input logic signed [COORD_BITS-1:0]          in_bottom_z,
  input logic        [scop_pkg::RADIUS_BITS-1:0] in_capsule_radius,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic                                  out_hit,
  input logic        [1:0]                     out_region
);

  // A stalled query beat stays on the port unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid
      && $stable(in_sphere_x) && $stable(in_sphere_y) && $stable(in_sphere_z)
      && $stable(in_sphere_radius) && $stable(in_top_x) && $stable(in_top_y)
      && $stable(in_top_z) && $stable(in_bottom_x) && $stable(in_bottom_y)
      && $stable(in_bottom_z) && $stable(in_capsule_radius))
    else $error("query beat changed while stalled");

  // A stalled result beat stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_region))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // With the receiver taking results, the pipeline never pushes back.
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled although output is free");

endmodule

bind sphere_capsule_overlap_unit scop_checker #(
  .COORD_BITS(COORD_BITS)
) u_scop_checker (.*);

// ===== tb/sv/sphere_capsule_overlap_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sphere_capsule_overlap_unit: directed and random queries,
// each checked against a pinned outcome or an exact integer model of the overlap test.
// Depends on scop_pkg and the RTL of the unit; no files or arguments are read.
module sphere_capsule_overlap_unit_tb;

  localparam int COORD_BITS = 16;
  localparam int CMAX = 32767;
  localparam int CMIN = -32768;
  localparam int RMAX = 32767;
  localparam int PHASE_QUERIES = 150;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx, sy, sz;
    logic [scop_pkg::RADIUS_BITS-1:0] sr;
    logic signed [COORD_BITS-1:0] tx, ty, tz;
    logic signed [COORD_BITS-1:0] bx, by, bz;
    logic [scop_pkg::RADIUS_BITS-1:0] cr;
  } query_t;

  typedef struct packed {
    logic hit;
    scop_pkg::region_t region;
  } outcome_t;

  typedef struct packed {
    query_t q;
    logic pinned;
    outcome_t want;
  } case_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  query_t drive_q = '0;
  logic in_stall;
  logic out_valid;
  logic out_hit;
  logic [1:0] out_region;

  outcome_t expected_outcomes[$];
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int fault_count = 0;
  int queries_sent = 0;
  int results_checked = 0;
  int hits_seen = 0;
  int region_seen[4] = '{0, 0, 0, 0};

  sphere_capsule_overlap_unit #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sphere_x(drive_q.sx),
    .in_sphere_y(drive_q.sy),
    .in_sphere_z(drive_q.sz),
    .in_sphere_radius(drive_q.sr),
    .in_top_x(drive_q.tx),
    .in_top_y(drive_q.ty),
    .in_top_z(drive_q.tz),
    .in_bottom_x(drive_q.bx),
    .in_bottom_y(drive_q.by),
    .in_bottom_z(drive_q.bz),
    .in_capsule_radius(drive_q.cr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hit(out_hit),
    .out_region(out_region)
  );

  always #5 clk = ~clk;

  function automatic int span_rand(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic int idle_length();
    if ($urandom_range(9, 0) == 0) begin
      return int'($urandom_range(40, 8));
    end
    return int'($urandom_range(3, 1));
  endfunction

  function automatic query_t make_query(int sx, int sy, int sz, int sr, int tx, int ty, int tz,
                                        int bx, int by, int bz, int cr);
    query_t q;
    q.sx = COORD_BITS'(sx);
    q.sy = COORD_BITS'(sy);
    q.sz = COORD_BITS'(sz);
    q.sr = scop_pkg::RADIUS_BITS'(sr);
    q.tx = COORD_BITS'(tx);
    q.ty = COORD_BITS'(ty);
    q.tz = COORD_BITS'(tz);
    q.bx = COORD_BITS'(bx);
    q.by = COORD_BITS'(by);
    q.bz = COORD_BITS'(bz);
    q.cr = scop_pkg::RADIUS_BITS'(cr);
    return q;
  endfunction

  function automatic case_t case_row(int sx, int sy, int sz, int sr, int tx, int ty, int tz,
                                     int bx, int by, int bz, int cr,
                                     logic pinned, logic hit, scop_pkg::region_t region);
    case_t row;
    row.q = make_query(sx, sy, sz, sr, tx, ty, tz, bx, by, bz, cr);
    row.pinned = pinned;
    row.want.hit = hit;
    row.want.region = region;
    return row;
  endfunction

  // The interior test compares |v x d|^2 with (r1 + r2)^2 * |d|^2, which needs
  // more than 64 bits, so those products are formed at 128 bits.
  function automatic outcome_t predict_overlap(query_t q);
    longint s[3], tp[3], bt[3], d[3], v[3], c[3];
    longint dot_vd, len_sq, rad_sum, rad_sq, dist_sq;
    logic signed [127:0] w[3];
    logic signed [127:0] rad_w, len_w, cross_sq, reach_sq;
    outcome_t o;
    int i;
    s[0] = q.sx;
    s[1] = q.sy;
    s[2] = q.sz;
    tp[0] = q.tx;
    tp[1] = q.ty;
    tp[2] = q.tz;
    bt[0] = q.bx;
    bt[1] = q.by;
    bt[2] = q.bz;
    for (i = 0; i < 3; i++) begin
      d[i] = bt[i] - tp[i];
      v[i] = s[i] - tp[i];
    end
    rad_sum = longint'(q.sr) + longint'(q.cr);
    rad_sq = rad_sum * rad_sum;
    dot_vd = d[0] * v[0] + d[1] * v[1] + d[2] * v[2];
    len_sq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    if (len_sq == 0 || dot_vd <= 0) begin
      o.region = scop_pkg::REGION_TOP;
      dist_sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      o.hit = dist_sq < rad_sq;
    end else if (dot_vd > len_sq) begin
      o.region = scop_pkg::REGION_BOTTOM;
      dist_sq = (s[0] - bt[0]) * (s[0] - bt[0]) + (s[1] - bt[1]) * (s[1] - bt[1])
              + (s[2] - bt[2]) * (s[2] - bt[2]);
      o.hit = dist_sq < rad_sq;
    end else begin
      o.region = scop_pkg::REGION_INTERIOR;
      c[0] = v[1] * d[2] - v[2] * d[1];
      c[1] = v[2] * d[0] - v[0] * d[2];
      c[2] = v[0] * d[1] - v[1] * d[0];
      for (i = 0; i < 3; i++) begin
        w[i] = c[i];
      end
      cross_sq = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
      rad_w = rad_sq;
      len_w = len_sq;
      reach_sq = rad_w * len_w;
      o.hit = cross_sq < reach_sq;
    end
    return o;
  endfunction

  // Most random queries are built around one region so that the closest-point
  // choice, the boundary ratios and near-touching distances are all reached.
  function automatic query_t random_query();
    int kind, cx, cy, cz, tx, ty, tz, a, b, c, r1, r2;
    kind = int'($urandom_range(99, 0));
    cx = span_rand(-30000, 30000);
    cy = span_rand(-30000, 30000);
    cz = span_rand(-30000, 30000);
    tx = cx + span_rand(-40, 40);
    ty = cy + span_rand(-40, 40);
    tz = cz + span_rand(-40, 40);
    a = span_rand(-40, 40);
    b = span_rand(-40, 40);
    c = span_rand(-40, 40);
    r1 = int'($urandom_range(30, 0));
    r2 = int'($urandom_range(30, 0));
    if (kind < 20) begin
      return make_query(span_rand(CMIN, CMAX), span_rand(CMIN, CMAX), span_rand(CMIN, CMAX),
                        int'($urandom_range(RMAX, 0)),
                        span_rand(CMIN, CMAX), span_rand(CMIN, CMAX), span_rand(CMIN, CMAX),
                        span_rand(CMIN, CMAX), span_rand(CMIN, CMAX), span_rand(CMIN, CMAX),
                        int'($urandom_range(RMAX, 0)));
    end else if (kind < 55) begin
      return make_query(cx + span_rand(-60, 60), cy + span_rand(-60, 60), cz + span_rand(-60, 60),
                        r1, tx, ty, tz, tx + a, ty + b, tz + c, r2);
    end else if (kind < 65) begin
      return make_query(tx + span_rand(-40, 40), ty + span_rand(-40, 40), tz + span_rand(-40, 40),
                        r1, tx, ty, tz, tx, ty, tz, r2);
    end else if (kind < 77) begin
      return make_query(tx + b, ty - a, tz, r1, tx, ty, tz, tx + a, ty + b, tz + c, r2);
    end else if (kind < 89) begin
      return make_query(tx + a + b, ty + b - a, tz + c, r1, tx, ty, tz, tx + a, ty + b, tz + c,
                        r2);
    end
    a = span_rand(CMIN, CMAX);
    b = span_rand(CMIN, CMAX);
    c = span_rand(CMIN, CMAX);
    tx = span_rand(CMIN, CMAX);
    ty = span_rand(CMIN, CMAX);
    tz = span_rand(CMIN, CMAX);
    return make_query((a + tx) / 2 + span_rand(-2000, 2000), (b + ty) / 2 + span_rand(-2000, 2000),
                      (c + tz) / 2 + span_rand(-2000, 2000), int'($urandom_range(RMAX, 0)),
                      tx, ty, tz, a, b, c, int'($urandom_range(RMAX, 0)));
  endfunction

  task automatic send_query(query_t q, outcome_t want);
    @(negedge clk);
    drive_q <= q;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    expected_outcomes.push_back(want);
    queries_sent++;
  endtask

  task automatic idle_gap();
    int n;
    if (int'($urandom_range(99, 0)) < gap_pct) begin
      n = idle_length();
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (int'($urandom_range(99, 0)) < stall_pct) begin
        stall_left <= idle_length();
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      hits_seen += int'(out_hit);
      region_seen[out_region]++;
      if (expected_outcomes.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("Unexpected result beat: hit=%0b region=%0d", out_hit, out_region);
        end
      end else begin
        want = expected_outcomes.pop_front();
        if (out_hit !== want.hit || out_region !== want.region) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("Mismatch on result %0d: expected hit=%0b region=%0d, got hit=%0b region=%0d",
                     results_checked, want.hit, want.region, out_hit, out_region);
          end
        end
      end
    end
  end

  initial begin : stimulus
    case_t rows[$];
    query_t q;
    int phase;
    int k;
    int gap_plan[4] = '{0, 30, 10, 60};
    int stall_plan[4] = '{0, 30, 70, 10};
    rows = '{
      case_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, scop_pkg::REGION_TOP),
      case_row(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, scop_pkg::REGION_TOP),
      case_row(10, 0, 0, 4, 0, 0, 0, 0, 0, 0, 6, 1'b1, 1'b0, scop_pkg::REGION_TOP),
      case_row(9, 0, 0, 4, 0, 0, 0, 0, 0, 0, 6, 1'b1, 1'b1, scop_pkg::REGION_TOP),
      case_row(5, 0, 0, 3, 0, 0, 0, 0, 0, 10, 3, 1'b1, 1'b1, scop_pkg::REGION_TOP),
      case_row(3, 0, 10, 1, 0, 0, 0, 0, 0, 10, 2, 1'b1, 1'b0, scop_pkg::REGION_INTERIOR),
      case_row(0, 0, 15, 3, 0, 0, 0, 0, 0, 10, 3, 1'b1, 1'b1, scop_pkg::REGION_BOTTOM),
      case_row(0, 0, -5, 3, 0, 0, 0, 0, 0, 10, 3, 1'b1, 1'b1, scop_pkg::REGION_TOP),
      case_row(4, 0, 5, 2, 0, 0, 0, 0, 0, 10, 1, 1'b1, 1'b0, scop_pkg::REGION_INTERIOR),
      case_row(CMIN, CMIN, CMIN, RMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, RMAX,
               1'b1, 1'b1, scop_pkg::REGION_TOP),
      case_row(CMAX, CMAX, CMAX, RMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, RMAX,
               1'b1, 1'b0, scop_pkg::REGION_TOP),
      case_row(CMAX, CMAX, CMAX, 0, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0,
               1'b1, 1'b0, scop_pkg::REGION_TOP),
      case_row(CMIN, CMIN, CMIN, 0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0,
               1'b1, 1'b0, scop_pkg::REGION_INTERIOR),
      case_row(CMIN, CMIN, CMIN, 1, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0,
               1'b1, 1'b1, scop_pkg::REGION_INTERIOR),
      case_row(0, 0, 0, 0, CMIN, 0, 0, CMAX, 0, 0, 0,
               1'b1, 1'b0, scop_pkg::REGION_INTERIOR),
      case_row(0, 1, 0, 1, CMIN, 0, 0, CMAX, 0, 0, 0,
               1'b1, 1'b0, scop_pkg::REGION_INTERIOR),
      case_row(CMAX, CMIN, CMAX, RMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, RMAX,
               1'b0, 1'b0, scop_pkg::REGION_INTERIOR),
      case_row(CMIN, CMAX, CMIN, RMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, 16384,
               1'b0, 1'b0, scop_pkg::REGION_INTERIOR),
      case_row(12345, -23456, 345, 20000, -1000, 2000, -3000, 4000, -5000, 6000, 7000,
               1'b0, 1'b0, scop_pkg::REGION_INTERIOR),
      case_row(-21846, 21845, -1, 10922, 1, -2, 3, -300, 400, -500, 21845,
               1'b0, 1'b0, scop_pkg::REGION_INTERIOR)
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gap_pct = 25;
    stall_pct = 25;
    foreach (rows[i]) begin
      if (rows[i].pinned) begin
        send_query(rows[i].q, rows[i].want);
      end else begin
        send_query(rows[i].q, predict_overlap(rows[i].q));
      end
      idle_gap();
    end
    wait_drained();
    for (phase = 0; phase < 4; phase++) begin
      gap_pct = gap_plan[phase];
      stall_pct = stall_plan[phase];
      for (k = 0; k < PHASE_QUERIES; k++) begin
        q = random_query();
        send_query(q, predict_overlap(q));
        idle_gap();
      end
      wait_drained();
    end
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d queries (%0d directed), %0d of them hits.",
             results_checked, queries_sent, rows.size(), hits_seen);
    $display("Closest point was interior %0d, bottom end %0d, top end %0d times.",
             region_seen[scop_pkg::REGION_INTERIOR], region_seen[scop_pkg::REGION_BOTTOM],
             region_seen[scop_pkg::REGION_TOP]);
    if (fault_count == 0) begin
      $display("PASS sphere_capsule_overlap_unit");
    end else begin
      $display("FAIL sphere_capsule_overlap_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("Timeout with %0d results still outstanding.", expected_outcomes.size());
    $display("FAIL sphere_capsule_overlap_unit");
    $finish;
  end

endmodule
